@@ rtl/core/fdhc_pkg.sv @@
// Shared types, constants and helpers for the footswitch debounce/hold/combo block.
package fdhc_pkg;

	localparam int PORT_W      = 8;
	localparam int TIME_W      = 32;
	localparam int MS_W        = 16;
	localparam int PIN_MAP_W   = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 18;
	localparam int KIND_W      = 3;
	localparam int SW_W        = 3;
	localparam int MODE_W      = 2;
	localparam int EV_CNT_W    = 3;

	localparam int SWITCH_COUNT_DEF = 6;
	localparam int MAPPED_SWITCHES  = 6;
	localparam int MAX_EVENTS       = 7;
	localparam int QUEUE_DEPTH      = 2;

	// switches that form the network-reset combo
	localparam int COMBO_A = 4;
	localparam int COMBO_B = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_MAP  = 3'd4;

	localparam logic [MS_W-1:0]      DEBOUNCE_RST = 16'd50;
	localparam logic [MS_W-1:0]      HOLD_RST     = 16'd1000;
	localparam logic [MS_W-1:0]      COMBO_RST    = 16'd5000;
	localparam logic [PIN_MAP_W-1:0] PIN_MAP_RST  = 18'd181896;

	localparam logic [KIND_W-1:0] EV_TAP      = 3'd0;
	localparam logic [KIND_W-1:0] EV_MODE     = 3'd1;
	localparam logic [KIND_W-1:0] EV_UP       = 3'd2;
	localparam logic [KIND_W-1:0] EV_DOWN     = 3'd3;
	localparam logic [KIND_W-1:0] EV_NETRESET = 3'd4;

	localparam logic [MODE_W-1:0] MODE_FX = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CM = 2'd3;

	typedef struct packed {
		logic                 enable;
		logic [MS_W-1:0]      debounce;
		logic [MS_W-1:0]      hold;
		logic [MS_W-1:0]      combo;
		logic [PIN_MAP_W-1:0] pin_map;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SW_W-1:0]   sw;
		logic [MODE_W-1:0] mode;
		logic              last;
	} ev_t;

	// port bit of a switch: mapped ones from the pin map, the rest by own index
	function automatic logic [2:0] port_bit(input int sw, input logic [PIN_MAP_W-1:0] map);
		logic [2:0] r;
		if (sw < MAPPED_SWITCHES) r = map[3*sw +: 3];
		else r = 3'(sw);
		return r;
	endfunction

	// switches with a long-press action
	function automatic logic has_long(input int sw);
		return (sw == 0) || (sw == 1) || (sw == 2) || (sw == COMBO_A) || (sw == COMBO_B);
	endfunction

endpackage

@@ rtl/core/fdhc_scan_if.sv @@
// Scan input channel: raw port byte and timestamp.
interface fdhc_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_pins;
	logic [31:0] now_ms;
	modport source (output valid, output raw_pins, output now_ms, input ready);
	modport sink   (input valid, input raw_pins, input now_ms, output ready);
endinterface

@@ rtl/core/fdhc_event_if.sv @@
// Event output channel.
interface fdhc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [2:0] switch_index;
	logic [1:0] mode_now;
	logic       last_event;
	modport source (output valid, output event_kind, output switch_index, output mode_now,
		output last_event, input ready);
	modport sink   (input valid, input event_kind, input switch_index, input mode_now,
		input last_event, output ready);
endinterface

@@ rtl/core/fdhc_cfg_if.sv @@
// Configuration write channel.
interface fdhc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [17:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/fdhc_front.sv @@
// Front end: per-switch debounce, press/hold tracking and combo detection.
module fdhc_front import fdhc_pkg::*; #(
	parameter int SWITCH_COUNT = SWITCH_COUNT_DEF,
	parameter int REC_W        = 2*SWITCH_COUNT + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PORT_W-1:0]   raw_pins,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic                q_full,
	output logic                q_push,
	output logic [REC_W-1:0]    q_rec
);

	logic [SWITCH_COUNT-1:0] lv_q, pf_q, hd_q;
	logic [TIME_W-1:0]       ct_q [SWITCH_COUNT];
	logic [TIME_W-1:0]       pt_q [SWITCH_COUNT];
	logic [TIME_W-1:0]       cs_q;
	logic                    rf_q;

	logic [SWITCH_COUNT-1:0] lvl, stable, new_press, held, pf1, hd2, act, tap, pf_fin, hd_fin;
	logic [TIME_W-1:0]       ct_n [SWITCH_COUNT];
	logic [TIME_W-1:0]       pt_n [SWITCH_COUNT];
	logic [TIME_W-1:0]       dt_c [SWITCH_COUNT];
	logic [TIME_W-1:0]       dp_c [SWITCH_COUNT];
	logic [TIME_W-1:0]       dc_c, cs_n;
	logic                    combo, combo_due, net, rf_fin, take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < SWITCH_COUNT; i++) begin
			lvl[i]       = raw_pins[port_bit(i, cfg.pin_map)];
			dt_c[i]      = now_ms - ct_q[i];
			dp_c[i]      = now_ms - pt_q[i];
			ct_n[i]      = (lvl[i] != lv_q[i]) ? now_ms : ct_q[i];
			// a changed level restarts the window, so it cannot be stable yet
			stable[i]    = (lvl[i] == lv_q[i]) && (dt_c[i] > TIME_W'(cfg.debounce));
			new_press[i] = stable[i] && !lvl[i] && !pf_q[i];
			pf1[i]       = pf_q[i] || new_press[i];
			pt_n[i]      = new_press[i] ? now_ms : pt_q[i];
			held[i]      = new_press[i] ? (cfg.hold == '0)
				: (dp_c[i] >= TIME_W'(cfg.hold));
			hd2[i]       = new_press[i] ? 1'b0 : hd_q[i];
		end

		combo = stable[COMBO_A] && stable[COMBO_B] && !lvl[COMBO_A] && !lvl[COMBO_B]
			&& pf1[COMBO_A] && pf1[COMBO_B];
		dc_c      = now_ms - cs_q;
		// zero start means idle: the combo starts now
		combo_due = (cs_q == '0) ? (cfg.combo == '0) : (dc_c >= TIME_W'(cfg.combo));
		cs_n      = combo ? ((cs_q == '0) ? now_ms : cs_q) : '0;
		net       = combo && !rf_q && combo_due;
		if (combo) begin
			hd2[COMBO_A] = 1'b1;
			hd2[COMBO_B] = 1'b1;
		end

		for (int i = 0; i < SWITCH_COUNT; i++) begin
			act[i]    = stable[i] && !lvl[i] && pf1[i] && !hd2[i] && held[i] && has_long(i);
			tap[i]    = stable[i] && lvl[i] && pf1[i] && !hd2[i];
			pf_fin[i] = (stable[i] && lvl[i]) ? 1'b0 : pf1[i];
			hd_fin[i] = act[i] ? 1'b1 : ((stable[i] && lvl[i]) ? 1'b0 : hd2[i]);
		end

		rf_fin = (!pf_fin[COMBO_A] && !pf_fin[COMBO_B]) ? 1'b0 : (rf_q || net);
	end

	assign q_rec  = {act, act | tap, net};
	assign q_push = take && cfg.enable && (net || (|act) || (|tap));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= '1;
			pf_q <= '0;
			hd_q <= '0;
			cs_q <= '0;
			rf_q <= 1'b0;
			for (int i = 0; i < SWITCH_COUNT; i++) begin
				ct_q[i] <= '0;
				pt_q[i] <= '0;
			end
		end else if (take && cfg.enable) begin
			lv_q <= lvl;
			pf_q <= pf_fin;
			hd_q <= hd_fin;
			cs_q <= cs_n;
			rf_q <= rf_fin;
			for (int i = 0; i < SWITCH_COUNT; i++) begin
				ct_q[i] <= ct_n[i];
				pt_q[i] <= pt_n[i];
			end
		end
	end

endmodule

@@ rtl/core/fdhc_queue.sv @@
// Small FIFO of per-scan event records between front and back.
module fdhc_queue import fdhc_pkg::*; #(
	parameter int W     = 13,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop && !empty) rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/fdhc_back.sv @@
// Back end: serializes a record into event beats and keeps the mode state.
module fdhc_back import fdhc_pkg::*; #(
	parameter int SWITCH_COUNT = SWITCH_COUNT_DEF,
	parameter int REC_W        = 2*SWITCH_COUNT + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  logic [REC_W-1:0] q_rec,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output ev_t              out_ev
);

	localparam int PW    = SWITCH_COUNT + 1;
	localparam int SEL_W = $clog2(PW);
	localparam int IDX_W = $clog2(SWITCH_COUNT);

	logic                    work_q, ov_q;
	logic [PW-1:0]           pend_q;
	logic [SWITCH_COUNT-1:0] act_q;
	logic [EV_CNT_W-1:0]     cnt_q;
	logic [MODE_W-1:0]       cur_q, sav_q;
	ev_t                     ev_q;

	logic [SEL_W-1:0]  sel;
	logic [IDX_W-1:0]  sw_idx;
	logic              is_net, is_act, last, adv;
	logic [PW-1:0]     rest;
	logic [KIND_W-1:0] kind;
	logic [SW_W-1:0]   sw_c;
	logic [MODE_W-1:0] mode_n, sav_n;

	always_comb begin
		sel = '0;
		for (int i = PW - 1; i >= 0; i--) begin
			if (pend_q[i]) sel = SEL_W'(i);
		end
		is_net = (sel == '0);
		sw_idx = IDX_W'(sel - SEL_W'(1));
		sw_c   = is_net ? SW_W'(COMBO_A) : SW_W'(sw_idx);
		is_act = !is_net && act_q[sw_idx];
		mode_n = cur_q;
		sav_n  = sav_q;
		kind   = EV_TAP;
		if (is_net) begin
			kind = EV_NETRESET;
		end else if (is_act) begin
			case (sw_c)
				3'd0: begin
					kind   = EV_MODE;
					mode_n = (cur_q == MODE_FX) ? MODE_SC : MODE_FX;
				end
				3'd1: begin
					kind   = EV_MODE;
					mode_n = (cur_q == MODE_PR) ? MODE_SC : MODE_PR;
				end
				3'd2: begin
					kind = EV_MODE;
					// custom mode goes back to the remembered mode
					if (cur_q == MODE_CM) begin
						mode_n = sav_q;
					end else begin
						sav_n  = cur_q;
						mode_n = MODE_CM;
					end
				end
				3'd4:    kind = EV_UP;
				3'd5:    kind = EV_DOWN;
				default: kind = EV_TAP;
			endcase
		end
		rest = pend_q & ~(PW'(1) << sel);
		last = (rest == '0) || (cnt_q == EV_CNT_W'(MAX_EVENTS - 1));
		adv  = work_q && (!ov_q || out_ready);
	end

	assign q_pop     = !work_q && !q_empty;
	assign out_valid = ov_q;
	assign out_ev    = ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= 1'b0;
			ov_q   <= 1'b0;
			cnt_q  <= '0;
			cur_q  <= MODE_FX;
			sav_q  <= MODE_FX;
		end else begin
			if (q_pop) begin
				work_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) work_q <= 1'b0;
			end
			if (adv) begin
				ov_q  <= 1'b1;
				cur_q <= mode_n;
				sav_q <= sav_n;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pend_q <= q_rec[PW-1:0];
			act_q  <= q_rec[REC_W-1:PW];
		end else if (adv) begin
			pend_q <= rest;
		end
		if (adv) ev_q <= '{kind: kind, sw: sw_c, mode: mode_n, last: last};
	end

endmodule

@@ rtl/core/footswitch_debounce_hold_combo.sv @@
// Top level of the footswitch debounce, long-press and combo block.
//
//   channel  | dir | beat payload                                   | handshake
//   ---------+-----+------------------------------------------------+-----------
//   scan     | in  | raw_pins[7:0] (active low), now_ms[31:0]       | valid/ready
//   events   | out | event_kind, switch_index, mode_now, last_event | valid/ready
//   cfg      | in  | index[2:0], data[17:0]                         | valid/ready
//
// A scan beat is taken whenever the two-entry record queue has room; while enabled,
// all per-switch debounce, hold and combo state is updated in the cycle it is taken.
// The back end loads a record, then sends one event beat per cycle while the sink
// is ready, at most seven per record, and loads the next record after the last beat.
// A stalled event sink backs up the queue only; scans stall once it is full.
// Reset is asynchronous; no clearing pass follows it. cfg is always ready.
module footswitch_debounce_hold_combo import fdhc_pkg::*; #(
	parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fdhc_scan_if.sink     scan,
	fdhc_event_if.source  events,
	fdhc_cfg_if.sink      cfg
);

	localparam int REC_W = 2*SWITCH_COUNT + 1;

	cfg_t             cfg_q;
	logic             q_push, q_pop, q_full, q_empty;
	logic [REC_W-1:0] rec_in, rec_out;
	ev_t              ev;

	// register file; writes to unknown indexes fall through
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{enable: 1'b0, debounce: DEBOUNCE_RST, hold: HOLD_RST,
				combo: COMBO_RST, pin_map: PIN_MAP_RST};
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ENABLE:   cfg_q.enable   <= cfg.data[0];
				CFG_DEBOUNCE: cfg_q.debounce <= cfg.data[MS_W-1:0];
				CFG_HOLD:     cfg_q.hold     <= cfg.data[MS_W-1:0];
				CFG_COMBO:    cfg_q.combo    <= cfg.data[MS_W-1:0];
				CFG_PIN_MAP:  cfg_q.pin_map  <= cfg.data[PIN_MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// front: classifies each scan into a record of pending events
	fdhc_front #(.SWITCH_COUNT(SWITCH_COUNT), .REC_W(REC_W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (scan.valid),
		.in_ready (scan.ready),
		.raw_pins (scan.raw_pins),
		.now_ms   (scan.now_ms),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (rec_in)
	);

	// decouples scan intake from event delivery
	fdhc_queue #(.W(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (rec_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (rec_out),
		.empty  (q_empty)
	);

	// back: network reset first, then switch events in switch order; mode lives here
	fdhc_back #(.SWITCH_COUNT(SWITCH_COUNT), .REC_W(REC_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rec     (rec_out),
		.q_pop     (q_pop),
		.out_valid (events.valid),
		.out_ready (events.ready),
		.out_ev    (ev)
	);

	assign events.event_kind   = ev.kind;
	assign events.switch_index = ev.sw;
	assign events.mode_now     = ev.mode;
	assign events.last_event   = ev.last;

endmodule

@@ rtl/core/fdhc_checker.sv @@
// Port-level checks on the event channel, bound to the top level.
module fdhc_checker import fdhc_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	fdhc_event_if.source events
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && !events.ready |=> events.valid)
		else $error("event valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && !events.ready |=> $stable(events.event_kind)
			&& $stable(events.switch_index) && $stable(events.mode_now)
			&& $stable(events.last_event))
		else $error("event payload changed while stalled");

	a_net_switch: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.event_kind == EV_NETRESET |-> events.switch_index == 3'd4)
		else $error("network reset not on switch 4");

	a_mode_switch: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.event_kind == EV_MODE |-> events.switch_index <= 3'd2)
		else $error("mode change from a switch without mode action");

	a_preset_switch: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && (events.event_kind == EV_UP || events.event_kind == EV_DOWN)
		|-> (events.event_kind == EV_UP) == (events.switch_index == 3'd4)
			&& (events.switch_index == 3'd4 || events.switch_index == 3'd5))
		else $error("preset step on wrong switch");

endmodule

bind footswitch_debounce_hold_combo fdhc_checker u_fdhc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.events (events)
);
